>>> rtl/core/svrp_pkg.sv
`default_nettype none

package svrp_pkg;

  localparam int SAMPLE_DEPTH    = 4096;
  localparam int SINE_TABLE_SIZE = 256;
  localparam int ADDR_W          = $clog2(SAMPLE_DEPTH);
  localparam int SIDX_W          = $clog2(SINE_TABLE_SIZE + 1);
  localparam int SINE_SHIFT      = $clog2(SINE_TABLE_SIZE);
  localparam int SINE_HALF       = SINE_TABLE_SIZE / 2;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned SERIES_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                 64'd110, 64'd156};

  localparam logic [2:0] CFG_PHASE_STEP   = 3'd0;
  localparam logic [2:0] CFG_VOICE_GAIN   = 3'd1;
  localparam logic [2:0] CFG_PAN_POSITION = 3'd2;
  localparam logic [2:0] CFG_STEREO       = 3'd3;
  localparam logic [2:0] CFG_BUFFER_LEN   = 3'd4;
  localparam logic [2:0] CFG_START_POS    = 3'd5;
  localparam logic [2:0] CFG_PLAY_LEN     = 3'd6;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_START = 2'd1,
    OP_STOP  = 2'd2,
    OP_TICK  = 2'd3
  } opcode_e;

  typedef struct packed {
    opcode_e            opcode;
    logic [11:0]        write_address;
    logic signed [15:0] write_left;
    logic signed [15:0] write_right;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               ended;
    logic               is_frame;
  } out_item_t;

  // One quarter-wave lookup: base entry, slope to the next entry, fraction.
  typedef struct packed {
    logic [15:0]        base;
    logic signed [16:0] slope;
    logic [15:0]        frac;
  } sine_tap_t;

  typedef logic [15:0] sine_rom_t [SINE_TABLE_SIZE + 1];

  // Shift-subtract quotient, used only while building the table at elaboration.
  function automatic longint unsigned div_u64(input longint unsigned num,
                                              input longint unsigned den);
    longint unsigned quo;
    longint unsigned rem;
    quo = '0;
    rem = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Quarter-wave sine in Q15 from a Taylor series in Q30, evaluated at elaboration.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t         rom;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   t;
    longint            sum;
    longint            v;
    for (int k = 0; k <= SINE_TABLE_SIZE; k++) begin
      x   = (HALF_PI_Q30 * longint'(k) + longint'(SINE_HALF)) >> SINE_SHIFT;
      x2  = (x * x) >> 30;
      t   = x;
      sum = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        t = div_u64((t * x2) >> 30, SERIES_DIV[n-1]);
        if ((n & 1) == 1) begin
          sum = sum - longint'(t);
        end else begin
          sum = sum + longint'(t);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      v = (sum + 16384) >>> 15;
      if (v > 32768) begin
        v = 32768;
      end
      rom[k] = 16'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

>>> rtl/core/sample_voice_resample_pan.sv
`default_nettype none

// One sample playback voice. Sample frames (left and right word side by side) live in a
// 4096-entry synchronous memory; a start item opens the play window, and each tick item
// reads two neighboring frames at the 13.16 read position, interpolates, pans with equal
// power from a quarter-wave sine table, applies the Q4.12 gain and saturates to Q1.15.
// A write, stop or non-empty start item keeps the voice idle; an empty start and a tick
// while silent go straight to the output step. A tick while playing runs two back-to-back
// memory reads on the single read port, then interpolation, pan multiply and gain multiply
// each behind a register, and a step to round, saturate and load the output register.
// A result waiting in the output register holds the voice before its next result only.
module sample_voice_resample_pan (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire svrp_pkg::in_item_t   in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output svrp_pkg::out_item_t       out_item_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [2:0]           cfg_index_i,
  input  wire logic [23:0]          cfg_data_i
);
  import svrp_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD2  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_INT  = 3'd3;
  localparam logic [2:0] S_PAN  = 3'd4;
  localparam logic [2:0] S_GAIN = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam int SPOS_W = 16 + SIDX_W;

  // configuration
  logic [23:0]        phase_step_q;
  logic signed [15:0] gain_q;
  logic signed [15:0] pan_q;
  logic               stereo_q;
  logic [12:0]        buf_len_q;
  logic [12:0]        start_q;
  logic [12:0]        play_len_q;

  // voice state
  logic [2:0]         state_q, state_d;
  logic [28:0]        pos_q;
  logic [12:0]        end_q;
  logic               playing_q;
  logic               direct_q;
  logic               dir_ended_q;

  // sample memory, left word in the upper half
  logic [31:0]        mem [SAMPLE_DEPTH];
  logic [31:0]        rd_q;
  logic [31:0]        w0_q;
  logic [ADDR_W-1:0]  rd_addr;

  // datapath registers
  logic signed [33:0] il_q, ir_q;
  logic signed [15:0] sl_q, sr_q;
  logic signed [32:0] lq_q, rq_q;
  logic signed [48:0] gl_q, gr_q;
  sine_tap_t          tap_l_q, tap_r_q;
  logic [15:0]        cl_q, cr_q;

  logic               out_valid_q;
  out_item_t          out_item_q;

  logic               accept;
  logic               out_space;
  logic [12:0]        len;
  logic [12:0]        len_m1;
  logic               zero_len;
  logic [12:0]        first_idx;
  logic [12:0]        second_idx;

  assign accept    = in_valid_i && in_ready_o;
  assign out_space = !out_valid_q || out_ready_i;
  assign len       = (buf_len_q > 13'(SAMPLE_DEPTH)) ? 13'(SAMPLE_DEPTH) : buf_len_q;
  assign len_m1    = len - 13'd1;
  assign zero_len  = (len == 13'd0);
  assign first_idx  = (pos_q[28:16] > len_m1) ? len_m1 : pos_q[28:16];
  assign second_idx = (first_idx < len_m1) ? first_idx + 13'd1 : len_m1;
  assign rd_addr    = (state_q == S_IDLE) ? first_idx[ADDR_W-1:0] : second_idx[ADDR_W-1:0];

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // ---------------------------------------------------------------- configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_step_q <= 24'd65536;
      gain_q       <= 16'sd4096;
      pan_q        <= 16'sd0;
      stereo_q     <= 1'b0;
      buf_len_q    <= 13'd1;
      start_q      <= 13'd0;
      play_len_q   <= 13'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PHASE_STEP:   phase_step_q <= cfg_data_i;
        CFG_VOICE_GAIN:   gain_q       <= $signed(cfg_data_i[15:0]);
        CFG_PAN_POSITION: pan_q        <= $signed(cfg_data_i[15:0]);
        CFG_STEREO:       stereo_q     <= cfg_data_i[0];
        CFG_BUFFER_LEN:   buf_len_q    <= cfg_data_i[12:0];
        CFG_START_POS:    start_q      <= cfg_data_i[12:0];
        CFG_PLAY_LEN:     play_len_q   <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk_i) begin
    if (accept && in_item_i.opcode == OP_WRITE &&
        {1'b0, in_item_i.write_address} < 13'(SAMPLE_DEPTH)) begin
      mem[in_item_i.write_address[ADDR_W-1:0]] <= {in_item_i.write_left,
                                                   in_item_i.write_right};
    end
    rd_q <= mem[rd_addr];
  end

  // ---------------------------------------------------------------- pan angle
  logic        pan_pos;
  logic [16:0] u_r, u_l;

  assign pan_pos = (pan_q > 16'sd0);

  always_comb begin
    if (!stereo_q) begin
      u_r = {1'b0, ~pan_q[15], pan_q[14:0]};
    end else if (pan_pos) begin
      u_r = {pan_q, 1'b0};
    end else begin
      u_r = {~pan_q[15], pan_q[14:0], 1'b0};
    end
    u_l = 17'h10000 - u_r;
  end

  function automatic sine_tap_t sine_lookup(input logic [16:0] u);
    sine_tap_t         tap;
    logic [SPOS_W-1:0] spos;
    logic [SIDX_W-1:0] idx;
    spos = SPOS_W'(u) * SPOS_W'(SINE_TABLE_SIZE);
    idx  = spos[SPOS_W-1:16];
    tap.frac = spos[15:0];
    if (idx >= SIDX_W'(SINE_TABLE_SIZE)) begin
      tap.base  = SINE_ROM[SINE_TABLE_SIZE];
      tap.slope = 17'sd0;
    end else begin
      tap.base  = SINE_ROM[idx];
      tap.slope = $signed({1'b0, SINE_ROM[idx + SIDX_W'(1)]}) - $signed({1'b0, SINE_ROM[idx]});
    end
    return tap;
  endfunction

  function automatic logic [15:0] sine_interp(input sine_tap_t tap);
    logic signed [33:0] prod;
    logic signed [17:0] val;
    prod = tap.slope * $signed({1'b0, tap.frac}) + 34'sd32768;
    val  = $signed({2'b00, tap.base}) + prod[33:16];
    return val[15:0];
  endfunction

  // ---------------------------------------------------------------- datapath
  logic signed [15:0] lw0, rw0, lw1, rw1;
  logic signed [16:0] dl, dr;
  logic signed [33:0] il_rnd, ir_rnd;
  logic signed [17:0] il_sum, ir_sum;
  logic signed [15:0] xl, xr, al, ar;
  logic signed [32:0] al_ext, ar_ext;
  logic signed [32:0] pl, pr;
  logic               ext_l, ext_r;

  assign lw0 = $signed(w0_q[31:16]);
  assign rw0 = $signed(w0_q[15:0]);
  assign lw1 = $signed(rd_q[31:16]);
  assign rw1 = $signed(rd_q[15:0]);
  assign dl  = 17'(lw1) - 17'(lw0);
  assign dr  = 17'(rw1) - 17'(rw0);

  assign il_rnd = il_q + 34'sd32768;
  assign ir_rnd = ir_q + 34'sd32768;
  assign il_sum = 18'(lw0) + il_rnd[33:16];
  assign ir_sum = 18'(rw0) + ir_rnd[33:16];

  // stereo keeps the near channel at unity on the side the pan leans toward and folds the far one in
  assign ext_l  = stereo_q && !pan_pos;
  assign ext_r  = stereo_q && pan_pos;
  assign xl     = ext_l ? sr_q : sl_q;
  assign xr     = ext_r ? sl_q : sr_q;
  assign al     = ext_l ? sl_q : 16'sd0;
  assign ar     = ext_r ? sr_q : 16'sd0;
  assign al_ext = {{2{al[15]}}, al, 15'b0};
  assign ar_ext = {{2{ar[15]}}, ar, 15'b0};
  assign pl     = xl * $signed({1'b0, cl_q});
  assign pr     = xr * $signed({1'b0, cr_q});

  function automatic logic signed [15:0] round_sat(input logic signed [48:0] g);
    logic signed [48:0] r;
    logic signed [21:0] v;
    r = g + 49'sd67108864;
    v = r[48:27];
    if (v > 22'sd32767) begin
      return 16'sh7fff;
    end else if (v < -22'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_RD2: begin
        w0_q    <= zero_len ? 32'd0 : rd_q;
        tap_l_q <= sine_lookup(u_l);
        tap_r_q <= sine_lookup(u_r);
      end
      S_MUL: begin
        il_q <= zero_len ? 34'sd0 : dl * $signed({1'b0, pos_q[15:0]});
        ir_q <= zero_len ? 34'sd0 : dr * $signed({1'b0, pos_q[15:0]});
        cl_q <= sine_interp(tap_l_q);
        cr_q <= sine_interp(tap_r_q);
      end
      S_INT: begin
        sl_q <= il_sum[15:0];
        sr_q <= stereo_q ? ir_sum[15:0] : il_sum[15:0];
      end
      S_PAN: begin
        lq_q <= al_ext + pl;
        rq_q <= ar_ext + pr;
      end
      S_GAIN: begin
        gl_q <= lq_q * gain_q;
        gr_q <= rq_q * gain_q;
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- control
  logic [12:0] s_clamp;
  logic [13:0] win_sum;
  logic [12:0] e_win;
  logic [28:0] new_pos;
  logic        reached;

  assign s_clamp = (start_q < len) ? start_q : len;
  assign win_sum = {1'b0, s_clamp} + {1'b0, play_len_q};
  assign e_win   = (play_len_q != 13'd0 && win_sum < {1'b0, len}) ? win_sum[12:0] : len;
  assign new_pos = pos_q + 29'(phase_step_q);
  assign reached = (new_pos >= {end_q, 16'b0});

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          unique case (in_item_i.opcode)
            OP_START: state_d = (s_clamp < e_win) ? S_IDLE : S_OUT;
            OP_TICK:  state_d = playing_q ? S_RD2 : S_OUT;
            default:  state_d = S_IDLE;
          endcase
        end
      end
      S_RD2:  state_d = S_MUL;
      S_MUL:  state_d = S_INT;
      S_INT:  state_d = S_PAN;
      S_PAN:  state_d = S_GAIN;
      S_GAIN: state_d = S_OUT;
      S_OUT:  state_d = out_space ? S_IDLE : S_OUT;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= 29'd0;
      end_q       <= 13'd0;
      playing_q   <= 1'b0;
      direct_q    <= 1'b0;
      dir_ended_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        unique case (in_item_i.opcode)
          OP_START: begin
            pos_q       <= {s_clamp, 16'b0};
            end_q       <= e_win;
            playing_q   <= (s_clamp < e_win);
            direct_q    <= 1'b1;
            dir_ended_q <= 1'b1;
          end
          OP_STOP: playing_q <= 1'b0;
          OP_TICK: begin
            direct_q    <= !playing_q;
            dir_ended_q <= 1'b0;
          end
          default: ;
        endcase
      end
      if (state_q == S_OUT && out_space) begin
        out_valid_q <= 1'b1;
        if (!direct_q) begin
          pos_q <= new_pos;
          if (reached) begin
            playing_q <= 1'b0;
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && out_space) begin
      if (direct_q) begin
        out_item_q.left_out  <= 16'sd0;
        out_item_q.right_out <= 16'sd0;
        out_item_q.ended     <= dir_ended_q;
        out_item_q.is_frame  <= !dir_ended_q;
      end else begin
        out_item_q.left_out  <= round_sat(gl_q);
        out_item_q.right_out <= round_sat(gr_q);
        out_item_q.ended     <= reached;
        out_item_q.is_frame  <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- assertions
  a_pos_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    playing_q |-> (pos_q[28:16] < end_q))
    else $error("read position outside play window while playing");

  a_end_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_q <= 13'(SAMPLE_DEPTH))
    else $error("end position beyond sample memory");

  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_space) |=> (out_valid_o && state_q == S_IDLE))
    else $error("result not presented after output stage");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE && state_q != S_OUT) |=> !out_valid_o || $past(out_valid_o))
    else $error("result appeared before the datapath finished");

endmodule

`default_nettype wire
